### hw/rtl/voxel_occupancy_map_neighbors_unit_assert.svh
// Assertion macros for the voxel occupancy map neighbours unit.
// Has no dependencies; the top level takes it in by include.
`ifndef VOXEL_OCCUPANCY_MAP_NEIGHBORS_UNIT_ASSERT_SVH
`define VOXEL_OCCUPANCY_MAP_NEIGHBORS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VOMN_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VOMN_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/vomn_pkg.sv
// Shared constants for the voxel occupancy map neighbours unit.
// Has no dependencies; used by the top level.
package vomn_pkg;

	localparam int MAX_X_DEF = 16;
	localparam int MAX_Y_DEF = 16;
	localparam int MAX_Z_DEF = 16;

	localparam int COORD_W   = 16;
	localparam int SIZE_W    = 5;
	localparam int OUT_IDX_W = 12;
	localparam int NB_NUM    = 6;
	localparam int OP_W      = 2;
	localparam int REG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

	localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	localparam logic [2:0] DIR_PX = 3'd0;
	localparam logic [2:0] DIR_MX = 3'd1;
	localparam logic [2:0] DIR_PY = 3'd2;
	localparam logic [2:0] DIR_MY = 3'd3;
	localparam logic [2:0] DIR_PZ = 3'd4;
	localparam logic [2:0] DIR_MZ = 3'd5;

endpackage

### hw/rtl/vomn_ram.sv
// Generic single write port, single read port RAM with registered read.
// Has no dependencies.
module vomn_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/vomn_mac.sv
// Shared multiply-add unit used for every index calculation.
// Has no dependencies; the result wraps at its width.
module vomn_mac #(
	parameter int W = 12
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	input  logic         sub,
	output logic [W-1:0] y
);

	logic [2*W-1:0] prod;

	assign prod = a * b;
	assign y    = sub ? (prod[W-1:0] - c) : (prod[W-1:0] + c);

endmodule

### hw/rtl/voxel_occupancy_map_neighbors_unit.sv
// Top level of the voxel occupancy map neighbours unit: sequencer and size registers.
// Depends on vomn_pkg, vomn_ram, vomn_mac and the assertion macro header.
//
//  channel   handshake                 payload
//  request   start, busy               op, first_x/y/z, last_x/y/z
//  result    done (one-cycle strobe)   cell_in_bounds .. minus_z_index
//  config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// An in-bounds query keeps busy high through S_PLANE, S_ROW, S_IDX, S_NB and S_LAST, where its
// result is registered. An out-of-bounds query leaves busy low; its result is registered on
// acceptance. An in-bounds clear is busy through S_PLANE, S_ROW and S_IDX, a fill of a
// non-empty clipped box through those and S_FILL, writing each cell in turn; any other request
// leaves busy low. The single multiply-add unit and single map read port set this order.
// After reset the map is wiped one cell a cycle, with busy high. The receiver cannot stall.
module voxel_occupancy_map_neighbors_unit #(
	parameter int MAX_X = vomn_pkg::MAX_X_DEF,
	parameter int MAX_Y = vomn_pkg::MAX_Y_DEF,
	parameter int MAX_Z = vomn_pkg::MAX_Z_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [vomn_pkg::OP_W-1:0]            op,
	input  logic signed [vomn_pkg::COORD_W-1:0]  first_x,
	input  logic signed [vomn_pkg::COORD_W-1:0]  first_y,
	input  logic signed [vomn_pkg::COORD_W-1:0]  first_z,
	input  logic signed [vomn_pkg::COORD_W-1:0]  last_x,
	input  logic signed [vomn_pkg::COORD_W-1:0]  last_y,
	input  logic signed [vomn_pkg::COORD_W-1:0]  last_z,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vomn_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [vomn_pkg::SIZE_W-1:0]          cfg_data,
	output logic                                 done,
	output logic                                 cell_in_bounds,
	output logic                                 cell_blocked,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       cell_index,
	output logic [vomn_pkg::NB_NUM-1:0]          free_mask,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       plus_x_index,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       minus_x_index,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       plus_y_index,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       minus_y_index,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       plus_z_index,
	output logic [vomn_pkg::OUT_IDX_W-1:0]       minus_z_index
);

`include "voxel_occupancy_map_neighbors_unit_assert.svh"

	localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
	localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW    = vomn_pkg::SIZE_W;
	localparam int CW    = vomn_pkg::COORD_W + 1;
	localparam int NB    = vomn_pkg::NB_NUM;
	localparam int OW    = vomn_pkg::OUT_IDX_W;

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_PLANE,
		S_ROW,
		S_IDX,
		S_FILL,
		S_NB,
		S_LAST
	} state_t;

	state_t state_q;

	logic [SW-1:0] size_x_q, size_y_q, size_z_q;
	logic [SW-1:0] sx_e, sy_e, sz_e;

	logic [vomn_pkg::OP_W-1:0] op_q;
	logic [SW-1:0] x_q, y_q, z_q, x1_q, y1_q, z1_q, cx_q, cy_q, cz_q;
	logic [IW-1:0] plane_q, row_q, pl_q, idx_q, wcnt_q;
	logic [IW-1:0] nidx_q [NB];
	logic [NB-1:0] nb_ex_q;
	logic [NB-2:0] nblk_q;
	logic [2:0]    k_q;

	logic          done_q, in_b_q, blk_q;
	logic [OW-1:0] cidx_q;
	logic [NB-1:0] mask_q;
	logic [OW-1:0] oidx_q [NB];

	logic [IW-1:0] mac_a, mac_b, mac_c, mac_y;
	logic          mac_sub;
	logic          ram_we, ram_wd, ram_rd;
	logic [IW-1:0] ram_wa;

	logic signed [CW-1:0] fx_w, fy_w, fz_w, lx_w, ly_w, lz_w;
	logic signed [CW-1:0] hx_w, hy_w, hz_w;
	logic signed [CW-1:0] x0_w, y0_w, z0_w, x1_w, y1_w, z1_w;
	logic                 box_ok, cell_ok, accept;
	logic [NB-1:0]        nb_ex_d;
	logic [NB-1:0]        mask_d;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Size registers above their parameter saturate.
	assign sx_e = (32'(size_x_q) > MAX_X) ? SW'(MAX_X) : size_x_q;
	assign sy_e = (32'(size_y_q) > MAX_Y) ? SW'(MAX_Y) : size_y_q;
	assign sz_e = (32'(size_z_q) > MAX_Z) ? SW'(MAX_Z) : size_z_q;

	always_comb begin
		fx_w = CW'(first_x);
		fy_w = CW'(first_y);
		fz_w = CW'(first_z);
		lx_w = CW'(last_x);
		ly_w = CW'(last_y);
		lz_w = CW'(last_z);
		hx_w = signed'(CW'(sx_e)) - CW'(1);
		hy_w = signed'(CW'(sy_e)) - CW'(1);
		hz_w = signed'(CW'(sz_e)) - CW'(1);
		x0_w = (fx_w < 0) ? '0 : fx_w;
		y0_w = (fy_w < 0) ? '0 : fy_w;
		z0_w = (fz_w < 0) ? '0 : fz_w;
		x1_w = (lx_w > hx_w) ? hx_w : lx_w;
		y1_w = (ly_w > hy_w) ? hy_w : ly_w;
		z1_w = (lz_w > hz_w) ? hz_w : lz_w;
		// An empty axis makes its clipped end negative, so the box comes out empty.
		box_ok  = (x0_w <= x1_w) && (y0_w <= y1_w) && (z0_w <= z1_w);
		cell_ok = (fx_w >= 0) && (fy_w >= 0) && (fz_w >= 0) &&
			(fx_w <= hx_w) && (fy_w <= hy_w) && (fz_w <= hz_w);
		nb_ex_d[vomn_pkg::DIR_PX] = ({1'b0, first_x[SW-1:0]} + 6'd1) < {1'b0, sx_e};
		nb_ex_d[vomn_pkg::DIR_MX] = (first_x[SW-1:0] != '0);
		nb_ex_d[vomn_pkg::DIR_PY] = ({1'b0, first_y[SW-1:0]} + 6'd1) < {1'b0, sy_e};
		nb_ex_d[vomn_pkg::DIR_MY] = (first_y[SW-1:0] != '0);
		nb_ex_d[vomn_pkg::DIR_PZ] = ({1'b0, first_z[SW-1:0]} + 6'd1) < {1'b0, sz_e};
		nb_ex_d[vomn_pkg::DIR_MZ] = (first_z[SW-1:0] != '0);
	end

	// Operand selection for the shared multiply-add unit.
	always_comb begin
		mac_a   = '0;
		mac_b   = '0;
		mac_c   = '0;
		mac_sub = 1'b0;
		unique case (state_q)
			S_PLANE: begin
				mac_a = IW'(sy_e);
				mac_b = IW'(sz_e);
			end
			S_ROW: begin
				mac_a = IW'(x_q);
				mac_b = IW'(sy_e);
				mac_c = IW'(y_q);
			end
			S_IDX: begin
				mac_a = row_q;
				mac_b = IW'(sz_e);
				mac_c = IW'(z_q);
			end
			S_FILL: begin
				mac_b = IW'(1);
				priority if (cz_q != z1_q) begin
					mac_a = idx_q;
					mac_c = IW'(1);
				end else if (cy_q != y1_q) begin
					mac_a = row_q;
					mac_c = IW'(sz_e);
				end else begin
					mac_a = pl_q;
					mac_c = plane_q;
				end
			end
			S_NB: begin
				mac_a   = idx_q;
				mac_b   = IW'(1);
				mac_sub = k_q[0];
				unique case (k_q)
					vomn_pkg::DIR_PX, vomn_pkg::DIR_MX: mac_c = plane_q;
					vomn_pkg::DIR_PY, vomn_pkg::DIR_MY: mac_c = IW'(sz_e);
					default:                            mac_c = IW'(1);
				endcase
			end
			default: begin
				mac_a = '0;
			end
		endcase
	end

	vomn_mac #(.W(IW)) u_mac (
		.a   (mac_a),
		.b   (mac_b),
		.c   (mac_c),
		.sub (mac_sub),
		.y   (mac_y)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = mac_y;
		ram_wd = 1'b0;
		unique case (state_q)
			S_WIPE: begin
				ram_we = 1'b1;
				ram_wa = wcnt_q;
			end
			S_FILL: begin
				ram_we = 1'b1;
				ram_wa = idx_q;
				ram_wd = 1'b1;
			end
			S_IDX: begin
				ram_we = (op_q == vomn_pkg::OP_CLEAR);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	vomn_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (mac_y),
		.rdata (ram_rd)
	);

	always_comb begin
		mask_d = nb_ex_q & ~{ram_rd, nblk_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= vomn_pkg::SIZE_RESET;
			size_y_q <= vomn_pkg::SIZE_RESET;
			size_z_q <= vomn_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vomn_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				vomn_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				vomn_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: size_x_q <= size_x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			wcnt_q  <= '0;
			done_q  <= 1'b0;
			k_q     <= '0;
			op_q    <= vomn_pkg::OP_FILL;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_WIPE: begin
					wcnt_q <= wcnt_q + IW'(1);
					if (wcnt_q == IW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= op;
						x_q     <= x0_w[SW-1:0];
						y_q     <= y0_w[SW-1:0];
						z_q     <= z0_w[SW-1:0];
						x1_q    <= x1_w[SW-1:0];
						y1_q    <= y1_w[SW-1:0];
						z1_q    <= z1_w[SW-1:0];
						nb_ex_q <= nb_ex_d;
						k_q     <= '0;
						unique case (op)
							vomn_pkg::OP_FILL: begin
								if (box_ok) begin
									state_q <= S_PLANE;
								end
							end
							vomn_pkg::OP_CLEAR: begin
								if (cell_ok) begin
									state_q <= S_PLANE;
								end
							end
							vomn_pkg::OP_QUERY: begin
								if (cell_ok) begin
									state_q <= S_PLANE;
								end else begin
									done_q <= 1'b1;
									in_b_q <= 1'b0;
									blk_q  <= 1'b0;
									cidx_q <= '0;
									mask_q <= '0;
									for (int i = 0; i < NB; i++) begin
										oidx_q[i] <= '0;
									end
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PLANE: begin
					plane_q <= mac_y;
					state_q <= S_ROW;
				end
				S_ROW: begin
					row_q   <= mac_y;
					state_q <= S_IDX;
				end
				S_IDX: begin
					idx_q <= mac_y;
					row_q <= mac_y;
					pl_q  <= mac_y;
					cx_q  <= x_q;
					cy_q  <= y_q;
					cz_q  <= z_q;
					unique case (op_q)
						vomn_pkg::OP_FILL:  state_q <= S_FILL;
						vomn_pkg::OP_QUERY: state_q <= S_NB;
						default:            state_q <= S_IDLE;
					endcase
				end
				S_FILL: begin
					idx_q <= mac_y;
					priority if (cz_q != z1_q) begin
						cz_q <= cz_q + SW'(1);
					end else if (cy_q != y1_q) begin
						row_q <= mac_y;
						cy_q  <= cy_q + SW'(1);
						cz_q  <= z_q;
					end else if (cx_q != x1_q) begin
						row_q <= mac_y;
						pl_q  <= mac_y;
						cx_q  <= cx_q + SW'(1);
						cy_q  <= y_q;
						cz_q  <= z_q;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_NB: begin
					nidx_q[k_q] <= mac_y;
					if (k_q == '0) begin
						blk_q <= ram_rd;
					end else begin
						nblk_q[k_q - 3'd1] <= ram_rd;
					end
					if (k_q == 3'(NB - 1)) begin
						state_q <= S_LAST;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_LAST: begin
					done_q  <= 1'b1;
					in_b_q  <= 1'b1;
					cidx_q  <= OW'(idx_q);
					mask_q  <= mask_d;
					for (int i = 0; i < NB; i++) begin
						oidx_q[i] <= mask_d[i] ? OW'(nidx_q[i]) : '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign cell_in_bounds = in_b_q;
	assign cell_blocked   = blk_q;
	assign cell_index     = cidx_q;
	assign free_mask      = mask_q;
	assign plus_x_index   = oidx_q[vomn_pkg::DIR_PX];
	assign minus_x_index  = oidx_q[vomn_pkg::DIR_MX];
	assign plus_y_index   = oidx_q[vomn_pkg::DIR_PY];
	assign minus_y_index  = oidx_q[vomn_pkg::DIR_MY];
	assign plus_z_index   = oidx_q[vomn_pkg::DIR_PZ];
	assign minus_z_index  = oidx_q[vomn_pkg::DIR_MZ];

	`VOMN_ASSERT_IMP(a_oob_zero, clk, arst_n, done && !cell_in_bounds,
		!cell_blocked && cell_index == '0 && free_mask == '0, "out-of-bounds result not zero")
	`VOMN_ASSERT_NXT(a_last_done, clk, arst_n, state_q == S_LAST, done && cell_in_bounds,
		"query finished without a result strobe")
	`VOMN_ASSERT_IMP(a_write_state, clk, arst_n, ram_we,
		state_q == S_WIPE || state_q == S_FILL || (state_q == S_IDX && op_q == vomn_pkg::OP_CLEAR),
		"map written outside a wipe, fill or clear")

endmodule

### tb/sv/voxel_occupancy_map_neighbors_unit_tb.sv
// Self-checking bench for the voxel occupancy map neighbours unit: directed and random
// fills, clears and queries over several grid sizes, checked against an internal model.
// Depends on vomn_pkg and the top level voxel_occupancy_map_neighbors_unit.
module voxel_occupancy_map_neighbors_unit_tb;
	import vomn_pkg::*;

	localparam int CELLS = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic signed [COORD_W-1:0] fx;
		logic signed [COORD_W-1:0] fy;
		logic signed [COORD_W-1:0] fz;
		logic signed [COORD_W-1:0] lx;
		logic signed [COORD_W-1:0] ly;
		logic signed [COORD_W-1:0] lz;
	} request_t;

	typedef struct packed {
		logic in_bounds;
		logic blocked;
		logic [OUT_IDX_W-1:0] cell_index;
		logic [NB_NUM-1:0] free_mask;
		logic [NB_NUM-1:0][OUT_IDX_W-1:0] nbr_index;
	} answer_t;

	class voxel_map_scoreboard;
		bit blocked_cells [CELLS];
		logic [SIZE_W-1:0] size_reg [3];
		answer_t queries_due [$];
		int errors;

		function new();
			size_reg = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
			errors = 0;
		endfunction

		function void set_size(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
			case (idx)
				REG_SIZE_X: size_reg[0] = val;
				REG_SIZE_Y: size_reg[1] = val;
				REG_SIZE_Z: size_reg[2] = val;
				default: ;
			endcase
		endfunction

		function int eff_size(int axis);
			int lim [3] = '{MAX_X_DEF, MAX_Y_DEF, MAX_Z_DEF};
			return (int'(size_reg[axis]) > lim[axis]) ? lim[axis] : int'(size_reg[axis]);
		endfunction

		function bit on_grid(int x, int y, int z, int sx, int sy, int sz);
			return x >= 0 && y >= 0 && z >= 0 && x < sx && y < sy && z < sz;
		endfunction

		function int pending();
			return queries_due.size();
		endfunction

		function void note_request(request_t r);
			int sx, sy, sz, fx, fy, fz, x0, x1, y0, y1, z0, z1, x, y, z, idx, nx, ny, nz, ni, k;
			int dx [6] = '{1, -1, 0, 0, 0, 0};
			int dy [6] = '{0, 0, 1, -1, 0, 0};
			int dz [6] = '{0, 0, 0, 0, 1, -1};
			answer_t a;
			sx = eff_size(0);
			sy = eff_size(1);
			sz = eff_size(2);
			fx = $signed(r.fx);
			fy = $signed(r.fy);
			fz = $signed(r.fz);
			case (r.op)
				OP_FILL: begin
					if (sx == 0 || sy == 0 || sz == 0)
						return;
					x0 = (fx < 0) ? 0 : fx;
					y0 = (fy < 0) ? 0 : fy;
					z0 = (fz < 0) ? 0 : fz;
					x1 = ($signed(r.lx) > sx - 1) ? sx - 1 : $signed(r.lx);
					y1 = ($signed(r.ly) > sy - 1) ? sy - 1 : $signed(r.ly);
					z1 = ($signed(r.lz) > sz - 1) ? sz - 1 : $signed(r.lz);
					for (x = x0; x <= x1; x++)
						for (y = y0; y <= y1; y++)
							for (z = z0; z <= z1; z++)
								blocked_cells[(x * sy * sz + y * sz + z) % CELLS] = 1'b1;
				end
				OP_CLEAR: begin
					if (on_grid(fx, fy, fz, sx, sy, sz))
						blocked_cells[(fx * sy * sz + fy * sz + fz) % CELLS] = 1'b0;
				end
				OP_QUERY: begin
					a = '0;
					if (on_grid(fx, fy, fz, sx, sy, sz)) begin
						idx = fx * sy * sz + fy * sz + fz;
						a.in_bounds = 1'b1;
						a.blocked = blocked_cells[idx % CELLS];
						a.cell_index = idx[OUT_IDX_W-1:0];
						for (k = 0; k < NB_NUM; k++) begin
							nx = fx + dx[k];
							ny = fy + dy[k];
							nz = fz + dz[k];
							if (on_grid(nx, ny, nz, sx, sy, sz)) begin
								ni = nx * sy * sz + ny * sz + nz;
								if (!blocked_cells[ni % CELLS]) begin
									a.free_mask[k] = 1'b1;
									a.nbr_index[k] = ni[OUT_IDX_W-1:0];
								end
							end
						end
					end
					queries_due.insert(queries_due.size(), a);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(answer_t got);
			answer_t want;
			int k;
			if (queries_due.size() == 0) begin
				report("result with no query waiting");
				return;
			end
			want = queries_due.pop_front();
			if (got.in_bounds !== want.in_bounds)
				report($sformatf("cell_in_bounds %0d, wanted %0d", got.in_bounds, want.in_bounds));
			if (got.blocked !== want.blocked)
				report($sformatf("cell_blocked %0d, wanted %0d", got.blocked, want.blocked));
			if (got.cell_index !== want.cell_index)
				report($sformatf("cell_index %0d, wanted %0d", got.cell_index, want.cell_index));
			if (got.free_mask !== want.free_mask)
				report($sformatf("free_mask %b, wanted %b", got.free_mask, want.free_mask));
			for (k = 0; k < NB_NUM; k++)
				if (got.nbr_index[k] !== want.nbr_index[k])
					report($sformatf("neighbour %0d index %0d, wanted %0d", k,
						got.nbr_index[k], want.nbr_index[k]));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OP_W-1:0] op = '0;
	logic signed [COORD_W-1:0] first_x = '0;
	logic signed [COORD_W-1:0] first_y = '0;
	logic signed [COORD_W-1:0] first_z = '0;
	logic signed [COORD_W-1:0] last_x = '0;
	logic signed [COORD_W-1:0] last_y = '0;
	logic signed [COORD_W-1:0] last_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic done;
	logic cell_in_bounds;
	logic cell_blocked;
	logic [OUT_IDX_W-1:0] cell_index;
	logic [NB_NUM-1:0] free_mask;
	logic [OUT_IDX_W-1:0] plus_x_index;
	logic [OUT_IDX_W-1:0] minus_x_index;
	logic [OUT_IDX_W-1:0] plus_y_index;
	logic [OUT_IDX_W-1:0] minus_y_index;
	logic [OUT_IDX_W-1:0] plus_z_index;
	logic [OUT_IDX_W-1:0] minus_z_index;

	voxel_map_scoreboard sb = new();
	answer_t seen_answer;
	int cycle_count = 0;

	voxel_occupancy_map_neighbors_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.first_x(first_x),
		.first_y(first_y),
		.first_z(first_z),
		.last_x(last_x),
		.last_y(last_y),
		.last_z(last_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.cell_in_bounds(cell_in_bounds),
		.cell_blocked(cell_blocked),
		.cell_index(cell_index),
		.free_mask(free_mask),
		.plus_x_index(plus_x_index),
		.minus_x_index(minus_x_index),
		.plus_y_index(plus_y_index),
		.minus_y_index(minus_y_index),
		.plus_z_index(plus_z_index),
		.minus_z_index(minus_z_index)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			seen_answer.in_bounds = cell_in_bounds;
			seen_answer.blocked = cell_blocked;
			seen_answer.cell_index = cell_index;
			seen_answer.free_mask = free_mask;
			seen_answer.nbr_index[DIR_PX] = plus_x_index;
			seen_answer.nbr_index[DIR_MX] = minus_x_index;
			seen_answer.nbr_index[DIR_PY] = plus_y_index;
			seen_answer.nbr_index[DIR_MY] = minus_y_index;
			seen_answer.nbr_index[DIR_PZ] = plus_z_index;
			seen_answer.nbr_index[DIR_MZ] = minus_z_index;
			sb.check_result(seen_answer);
		end
	end

	function automatic request_t mk(logic [OP_W-1:0] o, int fx, int fy, int fz,
		int lx, int ly, int lz);
		request_t r;
		r.op = o;
		r.fx = COORD_W'(fx);
		r.fy = COORD_W'(fy);
		r.fz = COORD_W'(fz);
		r.lx = COORD_W'(lx);
		r.ly = COORD_W'(ly);
		r.lz = COORD_W'(lz);
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] near_coord(int s);
		int v;
		if ($urandom_range(0, 7) == 0)
			return COORD_W'($urandom);
		v = $urandom_range(0, s + 1);
		return COORD_W'(v - 1);
	endfunction

	function automatic request_t random_request(int sx, int sy, int sz);
		request_t r;
		int pick, kind;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			r.op = OP_UNUSED;
		else if (pick < 30)
			r.op = OP_FILL;
		else if (pick < 62)
			r.op = OP_CLEAR;
		else
			r.op = OP_QUERY;
		r.fx = near_coord(sx);
		r.fy = near_coord(sy);
		r.fz = near_coord(sz);
		r.lx = COORD_W'($urandom);
		r.ly = COORD_W'($urandom);
		r.lz = COORD_W'($urandom);
		if (r.op == OP_FILL) begin
			kind = $urandom_range(0, 39);
			if (kind == 0) begin
				r.fx = COORD_W'(-$urandom_range(0, 32768));
				r.fy = COORD_W'(-$urandom_range(0, 32768));
				r.fz = COORD_W'(-$urandom_range(0, 32768));
				r.lx = 16'sh7FFF;
				r.ly = COORD_W'($urandom_range(sy, 32767));
				r.lz = COORD_W'($urandom_range(sz, 32767));
			end else if (kind > 2) begin
				r.lx = r.fx + COORD_W'($urandom_range(0, 1));
				r.ly = r.fy + COORD_W'($urandom_range(0, 1));
				r.lz = r.fz + COORD_W'($urandom_range(0, 1));
				if (kind == 3)
					r.ly = r.fy - 1'b1;
			end
		end
		return r;
	endfunction

	function automatic int next_gap(bit calm);
		if (calm || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 12);
	endfunction

	task automatic send_request(request_t r, int gap);
		start <= 1'b1;
		op <= r.op;
		first_x <= r.fx;
		first_y <= r.fy;
		first_z <= r.fz;
		last_x <= r.lx;
		last_y <= r.ly;
		last_z <= r.lz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(r);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sizes(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
		logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] vals [3];
		logic [REG_IDX_W-1:0] codes [3];
		int i;
		vals = '{sx, sy, sz};
		codes = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
		for (i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= codes[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.set_size(codes[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int n_items, bit calm);
		request_t r;
		int sx, sy, sz, count;
		sx = sb.eff_size(0);
		sy = sb.eff_size(1);
		sz = sb.eff_size(2);
		count = 0;
		while (count < n_items) begin
			r = random_request(sx, sy, sz);
			if (r.op != OP_UNUSED)
				count++;
			send_request(r, next_gap(calm));
			if (!calm && $urandom_range(0, 63) == 0)
				wait_quiet();
		end
	endtask

	initial begin
		request_t directed [$];
		logic [SIZE_W-1:0] px [8];
		logic [SIZE_W-1:0] py [8];
		logic [SIZE_W-1:0] pz [8];
		int p, i;
		px = '{5'd1, 5'd3, 5'd0, 5'd31, 5'd2, 5'd0, 5'd0, 5'd4};
		py = '{5'd1, 5'd7, 5'd4, 5'd31, 5'd16, 5'd0, 5'd0, 5'd4};
		pz = '{5'd1, 5'd2, 5'd4, 5'd31, 5'd1, 5'd0, 5'd0, 5'd4};
		directed = {
			mk(OP_QUERY, 0, 0, 0, 0, 0, 0),
			mk(OP_QUERY, 15, 15, 15, -1, -1, -1),
			mk(OP_QUERY, -1, 0, 0, 0, 0, 0),
			mk(OP_QUERY, 0, 16, 0, 0, 0, 0),
			mk(OP_QUERY, -32768, -32768, -32768, 0, 0, 0),
			mk(OP_QUERY, 32767, 32767, 32767, 0, 0, 0),
			mk(OP_FILL, 2, 2, 2, 4, 4, 4),
			mk(OP_QUERY, 3, 3, 3, 0, 0, 0),
			mk(OP_QUERY, 1, 3, 3, 0, 0, 0),
			mk(OP_QUERY, 5, 3, 3, 0, 0, 0),
			mk(OP_FILL, 6, 6, 6, 5, 9, 9),
			mk(OP_QUERY, 6, 6, 6, 0, 0, 0),
			mk(OP_FILL, -32768, -32768, -32768, 1, 1, 1),
			mk(OP_QUERY, 0, 0, 0, 0, 0, 0),
			mk(OP_QUERY, 2, 1, 1, 0, 0, 0),
			mk(OP_CLEAR, 3, 3, 3, 0, 0, 0),
			mk(OP_QUERY, 3, 3, 3, 0, 0, 0),
			mk(OP_CLEAR, -1, 3, 3, 0, 0, 0),
			mk(OP_CLEAR, 16, 0, 0, 0, 0, 0),
			mk(OP_UNUSED, 0, 0, 0, 15, 15, 15),
			mk(OP_QUERY, 8, 8, 8, 0, 0, 0),
			mk(OP_FILL, 14, 14, 14, 32767, 32767, 32767),
			mk(OP_QUERY, 15, 15, 15, 0, 0, 0),
			mk(OP_QUERY, 13, 14, 14, 0, 0, 0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait_quiet();
		write_sizes(5'd16, 5'd16, 5'd16);
		for (i = 0; i < directed.size(); i++)
			send_request(directed[i], next_gap(1'b0));
		wait_quiet();

		for (p = 0; p < 8; p++) begin
			if (p == 5 || p == 6)
				write_sizes(SIZE_W'($urandom_range(0, 31)), SIZE_W'($urandom_range(0, 31)),
					SIZE_W'($urandom_range(0, 31)));
			else
				write_sizes(px[p], py[p], pz[p]);
			run_phase(PHASE_ITEMS, p == 0 || p == 7);
			wait_quiet();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
